@@ hdl/hpt_pkg.sv @@
// Shared constants and types for the heading PID turn controller.
// Used by the multiplier, the serial divider and the top level; no dependencies.
`default_nettype none

package hpt_pkg;

    // Fixed-point position of the gains (unsigned Q8.16).
    localparam int GAIN_FRAC_BITS = 16;

    // Field widths.
    localparam int HEAD_W = 16;
    localparam int DT_W   = 10;
    localparam int GAIN_W = 24;
    localparam int TOL_W  = 15;
    localparam int ERR_W  = 16;
    localparam int SUM_W  = 40;
    localparam int DRV_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;
    localparam logic [TOL_W-1:0]     TOL_RESET  = 15'd150;

    // Angle wrap limits in hundredths of a degree.
    localparam logic signed [16:0] WRAP_HALF = 17'sd18000;
    localparam logic signed [16:0] WRAP_FULL = 17'sd36000;

    // Shared multiplier: signed gain-side operand times signed data operand.
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SUM_SPLIT = 20;

    // Serial divider for the derivative term.
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = DT_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Drive accumulator holds P + I + D exactly.
    localparam int ACC_W = 66;

    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [MUL_P_W-1:0] t_mul_p;

endpackage : hpt_pkg

`default_nettype wire

@@ hdl/hpt_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on hpt_pkg for the operand and product types.
`default_nettype none

module hpt_mul (
    input  wire logic           i_clk,
    input  wire hpt_pkg::t_mul_a i_a,
    input  wire hpt_pkg::t_mul_b i_b,
    output hpt_pkg::t_mul_p      o_prod
);
    import hpt_pkg::*;

    t_mul_p r_prod;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule : hpt_mul

`default_nettype wire

@@ hdl/hpt_div.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on hpt_pkg for the operand widths.
`default_nettype none

module hpt_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hpt_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [hpt_pkg::DIV_DEN_W-1:0] i_den,
    output logic                               o_busy,
    output logic [hpt_pkg::DIV_NUM_W-1:0]      o_quot
);
    import hpt_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   n_trial;
    logic                 n_ge;

    // Bring down the next numerator bit and try a subtraction.
    always_comb begin
        n_trial = {r_rem, r_q[DIV_NUM_W-1]};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Numerator shifts out while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DIV_NUM_W-2:0], n_ge};
            r_rem <= n_ge ? DIV_DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DIV_DEN_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

endmodule : hpt_div

`default_nettype wire

@@ hdl/heading_pid_turn_top.sv @@
// Heading PID turn controller, top level: config registers, sequencer,
// loop state and output register. Depends on hpt_pkg, hpt_mul and hpt_div.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one control tick: the
//   measured heading and the milliseconds since the previous tick.
// - Output channel (o_out_valid / i_out_ready) returns one result per tick:
//   drive speed, wrapped error, settled and zero-interval flags.
// - Registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata; the
//   user must write them only while the block is idle, which the block itself
//   does not enforce. Writing the target heading restarts the move.
// - A tick passes the shared multiplier five times and then waits on the
//   serial divider, which produces one quotient bit per cycle; a zero interval
//   skips the divider, and an already settled turn skips both units.
// - One tick is in work at a time; o_in_ready is high only between ticks.
//   The next tick can be taken while the previous result still waits.
// - If the receiver stalls, the finished tick holds in the sequencer until
//   the output register frees up.
// - Reset clears the loop state, the gains and the target; the tolerance
//   returns to 1.50 degrees.
`default_nettype none

module heading_pid_turn_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [hpt_pkg::HEAD_W-1:0]     i_measured_heading,
    input  wire logic [hpt_pkg::DT_W-1:0]       i_elapsed_ms,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [hpt_pkg::DRV_W-1:0]    o_drive_speed,
    output logic signed [hpt_pkg::ERR_W-1:0]    o_wrapped_error,
    output logic                                o_settled,
    output logic                                o_zero_interval,
    input  wire logic                           i_cfg_we,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import hpt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MDT  = 4'd1;
    localparam logic [3:0] S_MSUM = 4'd2;
    localparam logic [3:0] S_MP   = 4'd3;
    localparam logic [3:0] S_MIL  = 4'd4;
    localparam logic [3:0] S_MIH  = 4'd5;
    localparam logic [3:0] S_ACH  = 4'd6;
    localparam logic [3:0] S_DIVW = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // Configuration registers.
    logic [HEAD_W-1:0] r_target;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [TOL_W-1:0]  r_tol;

    // Loop state.
    logic signed [SUM_W-1:0] r_error_sum;
    logic signed [ERR_W-1:0] r_last_error;
    logic                    r_finished;

    // Per-tick working registers.
    logic [3:0]              r_state;
    logic signed [ERR_W-1:0] r_e;
    logic [DT_W-1:0]         r_dt;
    logic                    r_zero;
    logic                    r_skip;
    logic                    r_dneg;
    logic signed [ACC_W-1:0] r_acc;

    // Output register.
    logic                    r_out_valid;
    logic signed [DRV_W-1:0] r_drive;
    logic signed [ERR_W-1:0] r_werr;
    logic                    r_settled;
    logic                    r_zero_out;

    // Shared units.
    t_mul_a                 mul_a;
    t_mul_b                 mul_b;
    t_mul_p                 mul_p;
    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic                   div_busy;
    logic [DIV_NUM_W-1:0]   div_quot;

    // Next-value logic.
    logic signed [16:0]      n_e_raw;
    logic signed [16:0]      n_e_wrap;
    logic signed [ERR_W:0]   n_diff;
    logic signed [SUM_W:0]   n_sum_wide;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DIV_NUM_W:0] n_dq;
    logic signed [ACC_W-1:0] n_drive_full;
    logic [ACC_W-GAIN_FRAC_BITS-DRV_W:0] n_drive_hi;
    logic signed [DRV_W-1:0] n_drive;
    logic [ERR_W-1:0]        n_mag;
    logic                    n_settle;
    logic                    out_free;

    hpt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    hpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_dt),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Error wrap at input transfer, error change and integral update.
    always_comb begin
        n_e_raw = $signed({1'b0, r_target}) - $signed({1'b0, i_measured_heading});
        if (n_e_raw > WRAP_HALF) begin
            n_e_wrap = n_e_raw - WRAP_FULL;
        end else if (n_e_raw < -WRAP_HALF) begin
            n_e_wrap = n_e_raw + WRAP_FULL;
        end else begin
            n_e_wrap = n_e_raw;
        end

        n_diff = {r_e[ERR_W-1], r_e} - {r_last_error[ERR_W-1], r_last_error};

        n_sum_wide = {r_error_sum[SUM_W-1], r_error_sum} + mul_p[SUM_W:0];
        if (n_sum_wide[SUM_W] != n_sum_wide[SUM_W-1]) begin
            n_sum = n_sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = n_sum_wide[SUM_W-1:0];
        end
    end

    // Multiplier operand selection per step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MDT: begin
                mul_a = {1'b0, r_gain_d};
                mul_b = {{(MUL_B_W-ERR_W-1){n_diff[ERR_W]}}, n_diff};
            end
            S_MSUM: begin
                mul_a = {{(MUL_A_W-DT_W){1'b0}}, r_dt};
                mul_b = {{(MUL_B_W-ERR_W){r_e[ERR_W-1]}}, r_e};
            end
            S_MP: begin
                mul_a = {1'b0, r_gain_p};
                mul_b = {{(MUL_B_W-ERR_W){r_e[ERR_W-1]}}, r_e};
            end
            S_MIL: begin
                mul_a = {1'b0, r_gain_i};
                mul_b = {{(MUL_B_W-SUM_SPLIT){1'b0}}, r_error_sum[SUM_SPLIT-1:0]};
            end
            S_MIH: begin
                mul_a = {1'b0, r_gain_i};
                mul_b = {{(MUL_B_W-SUM_W+SUM_SPLIT){r_error_sum[SUM_W-1]}},
                         r_error_sum[SUM_W-1:SUM_SPLIT]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Derivative numerator magnitude goes to the divider.
    always_comb begin
        div_start = (r_state == S_MSUM) && !r_zero;
        div_num   = mul_p[MUL_P_W-1] ? DIV_NUM_W'(-mul_p) : mul_p[DIV_NUM_W-1:0];
        n_dq      = r_dneg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    end

    // Floor by the gain fraction, saturate, and check the settle window.
    always_comb begin
        n_drive_full = r_acc >>> GAIN_FRAC_BITS;
        n_drive_hi   = n_drive_full[ACC_W-GAIN_FRAC_BITS-1:DRV_W-1];
        if ((&n_drive_hi) || !(|n_drive_hi)) begin
            n_drive = n_drive_full[DRV_W-1:0];
        end else begin
            n_drive = n_drive_hi[ACC_W-GAIN_FRAC_BITS-DRV_W] ?
                      {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
        end
        n_mag    = r_e[ERR_W-1] ? ERR_W'(-r_e) : r_e;
        n_settle = (n_mag[TOL_W-1:0] < r_tol);
        out_free = !r_out_valid || i_out_ready;
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_tol    <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET: r_target <= i_cfg_wdata[HEAD_W-1:0];
                CFG_GAIN_P: r_gain_p <= i_cfg_wdata;
                CFG_GAIN_I: r_gain_i <= i_cfg_wdata;
                CFG_GAIN_D: r_gain_d <= i_cfg_wdata;
                CFG_TOL:    r_tol    <= i_cfg_wdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= r_finished ? S_FIN : S_MDT;
                    end
                end
                S_MDT:  r_state <= S_MSUM;
                S_MSUM: r_state <= S_MP;
                S_MP:   r_state <= S_MIL;
                S_MIL:  r_state <= S_MIH;
                S_MIH:  r_state <= S_ACH;
                S_ACH:  r_state <= S_DIVW;
                S_DIVW: begin
                    if (!div_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Loop state; a target write clears the move ahead of any update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_finished   <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index == CFG_TARGET)) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_finished   <= 1'b0;
        end else begin
            if (r_state == S_MP) begin
                r_error_sum  <= n_sum;
                r_last_error <= r_e;
            end
            if ((r_state == S_FIN) && out_free && !r_skip && n_settle) begin
                r_finished <= 1'b1;
            end
        end
    end

    // Tick payload, accumulator and output payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_e    <= n_e_wrap[ERR_W-1:0];
            r_dt   <= i_elapsed_ms;
            r_zero <= (i_elapsed_ms == '0);
            r_skip <= r_finished;
        end
        if (r_state == S_MSUM) begin
            r_dneg <= mul_p[MUL_P_W-1];
        end
        if (r_state == S_MIL) begin
            r_acc <= {{(ACC_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
        end
        if (r_state == S_MIH) begin
            r_acc <= r_acc + {{(ACC_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
        end
        if (r_state == S_ACH) begin
            r_acc <= r_acc + {mul_p, {SUM_SPLIT{1'b0}}};
        end
        if ((r_state == S_DIVW) && !div_busy && !r_zero) begin
            r_acc <= r_acc + {{(ACC_W-DIV_NUM_W-1){n_dq[DIV_NUM_W]}}, n_dq};
        end
        if ((r_state == S_FIN) && out_free) begin
            r_drive    <= (r_skip || n_settle) ? '0 : n_drive;
            r_werr     <= r_e;
            r_settled  <= r_skip || n_settle;
            r_zero_out <= r_zero;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_drive_speed   = r_drive;
    assign o_wrapped_error = r_werr;
    assign o_settled       = r_settled;
    assign o_zero_interval = r_zero_out;

    // A settled result never drives the motors.
    a_settled_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_settled |-> o_drive_speed == '0)
        else $error("settled result carries nonzero drive");

    // The divider is never left running between ticks.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    // A target write restarts the move.
    a_target_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == CFG_TARGET) |=>
            !r_finished && (r_error_sum == '0) && (r_last_error == '0))
        else $error("target write did not clear the loop state");

endmodule : heading_pid_turn_top

`default_nettype wire

@@ tb/tb_heading_pid_turn_top.sv @@
// Self-checking testbench for the heading PID turn controller (heading_pid_turn_top).
// Depends on hpt_pkg for widths and register indexes; a bit-exact predictor runs alongside.
// It needs no files or arguments.

module tb_heading_pid_turn_top;
    import hpt_pkg::*;

    // One result item as the block reports it.
    typedef struct {
        logic signed [DRV_W-1:0] drive;
        logic signed [ERR_W-1:0] err;
        logic                    settled;
        logic                    zero_dt;
    } t_turn_result;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_PRINTS   = 40;
    localparam int TIMEOUT      = 10_000_000;

    localparam int HEAD_MAX    = 2**HEAD_W - 1;
    localparam int DT_MAX      = 2**DT_W - 1;
    localparam int HEADING_MOD = int'(WRAP_FULL);
    localparam int MAX_HEADING = HEADING_MOD - 1;
    localparam int HALF_TURN   = int'(WRAP_HALF);
    localparam int MAX_GAIN    = 2**GAIN_W - 1;
    localparam int MAX_TOL     = HALF_TURN;
    localparam int DRV_MAX     = 2**(DRV_W-1) - 1;
    localparam int DRV_MIN     = -(2**(DRV_W-1));
    localparam longint SUM_HI  = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO  = -SUM_HI - 1;

    // Enough ticks at the largest error and interval to push the integral
    // far past the 16-bit drive range through the high multiplier half.
    localparam int INTEG_TICKS = 200;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic [HEAD_W-1:0]       meas_hd   = '0;
    logic [DT_W-1:0]         elapsed   = '0;
    logic                    out_ready = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    logic                    in_ready;
    logic                    out_valid;
    logic signed [DRV_W-1:0] drive_speed;
    logic signed [ERR_W-1:0] wrapped_error;
    logic                    settled;
    logic                    zero_interval;

    // Predictor copy of the registers and the loop state.
    logic [HEAD_W-1:0] tgt_heading = '0;
    logic [GAIN_W-1:0] kp = '0;
    logic [GAIN_W-1:0] ki = '0;
    logic [GAIN_W-1:0] kd = '0;
    logic [TOL_W-1:0]  tol = TOL_RESET;
    longint            integ_ms_sum = 0;
    int                prev_err = 0;
    bit                turn_done = 1'b0;

    t_turn_result drive_results_due[$];
    bit           idling = 1'b0;
    int           fail_count = 0;
    int           results_seen = 0;
    int           stall_left = 0;

    heading_pid_turn_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_measured_heading (meas_hd),
        .i_elapsed_ms       (elapsed),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_drive_speed      (drive_speed),
        .o_wrapped_error    (wrapped_error),
        .o_settled          (settled),
        .o_zero_interval    (zero_interval),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Computes the result of one control tick and advances the predicted state.
    function automatic t_turn_result predict_turn_step(input logic [HEAD_W-1:0] meas,
                                                       input logic [DT_W-1:0] dt);
        t_turn_result       r;
        int                 e;
        int                 mag;
        longint             d_part;
        longint             run_sum;
        longint             drv;
        logic signed [127:0] total;
        e = int'(tgt_heading) - int'(meas);
        if (e > HALF_TURN) begin
            e -= HEADING_MOD;
        end else if (e < -HALF_TURN) begin
            e += HEADING_MOD;
        end
        drv = 0;
        if (!turn_done) begin
            d_part = 0;
            if (dt != '0) begin
                d_part = (longint'(kd) * longint'(e - prev_err)) / longint'(dt);
            end
            prev_err = e;

            run_sum = integ_ms_sum + longint'(e) * longint'(dt);
            if (run_sum > SUM_HI) begin
                run_sum = SUM_HI;
            end
            if (run_sum < SUM_LO) begin
                run_sum = SUM_LO;
            end
            integ_ms_sum = run_sum;

            // Exact sum of the three terms, then floor by the arithmetic shift.
            total = longint'(kp) * longint'(e) + longint'(ki) * integ_ms_sum + d_part;
            total = total >>> GAIN_FRAC_BITS;
            if (total > DRV_MAX) begin
                drv = DRV_MAX;
            end else if (total < DRV_MIN) begin
                drv = DRV_MIN;
            end else begin
                drv = longint'(total);
            end

            mag = (e < 0) ? -e : e;
            if (mag < int'(tol)) begin
                turn_done = 1'b1;
                drv = 0;
            end
        end
        r.drive   = drv[DRV_W-1:0];
        r.err     = e[ERR_W-1:0];
        r.settled = turn_done;
        r.zero_dt = (dt == '0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < MAX_PRINTS) begin
            $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
        end
        fail_count++;
    endtask

    // Writes one register and mirrors it in the predictor; only called while idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET: begin
                tgt_heading  = val[HEAD_W-1:0];
                integ_ms_sum = 0;
                prev_err     = 0;
                turn_done    = 1'b0;
            end
            CFG_GAIN_P: kp = val[GAIN_W-1:0];
            CFG_GAIN_I: ki = val[GAIN_W-1:0];
            CFG_GAIN_D: kd = val[GAIN_W-1:0];
            CFG_TOL:    tol = val[TOL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drops the input valid and waits until every expected result has arrived.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (drive_results_due.size() != 0);
    endtask

    // Offers one tick, waits for its transfer and records the expected result.
    task automatic send_tick(input int meas, input int dt);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        meas_hd  <= HEAD_W'(meas);
        elapsed  <= DT_W'(dt);
        do @(posedge clk); while (!in_ready);
        drive_results_due.push_back(predict_turn_step(HEAD_W'(meas), DT_W'(dt)));
    endtask

    // Receiver side: random stall bursts while idling is on.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge clk) begin : check_results
        t_turn_result want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (drive_results_due.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                want = drive_results_due.pop_front();
                if (drive_speed !== want.drive) begin
                    report_mismatch("drive_speed", drive_speed, want.drive);
                end
                if (wrapped_error !== want.err) begin
                    report_mismatch("wrapped_error", wrapped_error, want.err);
                end
                if (settled !== want.settled) begin
                    report_mismatch("settled", settled, want.settled);
                end
                if (zero_interval !== want.zero_dt) begin
                    report_mismatch("zero_interval", zero_interval, want.zero_dt);
                end
            end
        end
    end

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 3 << GAIN_FRAC_BITS));
        endcase
    endfunction

    function automatic logic [TOL_W-1:0] pick_tol();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return TOL_W'(MAX_TOL);
            2: return TOL_RESET;
            3: return TOL_W'($urandom_range(0, MAX_TOL));
            default: return TOL_W'($urandom_range(0, 500));
        endcase
    endfunction

    function automatic logic [HEAD_W-1:0] pick_target();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return HEAD_W'(MAX_HEADING);
            default: return HEAD_W'($urandom_range(0, MAX_HEADING));
        endcase
    endfunction

    // Reset values: zero gains and target, tolerance of 1.50 degrees.
    task automatic test_reset_state();
        send_tick(150, 20);
        send_tick(149, 20);
        send_tick(MAX_HEADING, 0);
    endtask

    // Wrap limits on both sides, out-of-range headings and drive saturation.
    task automatic test_wrap_and_drive_limits();
        wait_idle();
        write_reg(CFG_TOL, 0);
        write_reg(CFG_GAIN_P, MAX_GAIN);
        write_reg(CFG_GAIN_I, 0);
        write_reg(CFG_GAIN_D, 0);
        write_reg(CFG_TARGET, 0);
        send_tick(HALF_TURN, 20);
        send_tick(HALF_TURN + 1, 20);
        send_tick(HEAD_MAX, DT_MAX);
        send_tick(HEADING_MOD, 1);
        send_tick(HALF_TURN - 1, 0);
        wait_idle();
        write_reg(CFG_TARGET, MAX_HEADING);
        send_tick(0, 512);
        send_tick(HALF_TURN - 1, 1);
        send_tick(HALF_TURN - 2, 20);
    endtask

    // Derivative truncation, the zero interval, floor rounding and the integral term.
    task automatic test_derivative_and_rounding();
        wait_idle();
        write_reg(CFG_GAIN_P, 1);
        write_reg(CFG_GAIN_D, MAX_GAIN);
        write_reg(CFG_TARGET, HALF_TURN);
        send_tick(HALF_TURN, DT_MAX);
        send_tick(0, 1);
        send_tick(HALF_TURN + 7, 7);
        send_tick(HALF_TURN + 3, 0);
        send_tick(HALF_TURN + 1, 3);
        wait_idle();
        write_reg(CFG_GAIN_D, 0);
        write_reg(CFG_GAIN_P, 0);
        write_reg(CFG_GAIN_I, MAX_GAIN);
        write_reg(CFG_TARGET, 100);
        send_tick(0, 1);
        send_tick(200, 2);
    endtask

    // Largest tolerance, the settling tick, frozen output after it, ignored indexes.
    task automatic test_settling_and_unknown_regs();
        wait_idle();
        write_reg(CFG_GAIN_I, 0);
        write_reg(CFG_GAIN_P, 1 << GAIN_FRAC_BITS);
        write_reg(CFG_TOL, MAX_TOL);
        for (int k = int'(CFG_TOL) + 1; k < 2**CFG_IDX_W; k++) begin
            write_reg(CFG_IDX_W'(k), '1);
        end
        write_reg(CFG_TARGET, 0);
        send_tick(HALF_TURN, 20);
        send_tick(HALF_TURN - 1, 20);
        send_tick(30000, 0);
    endtask

    // Builds a large negative integral with the largest error and interval.
    task automatic test_integral_growth();
        wait_idle();
        write_reg(CFG_TOL, 0);
        write_reg(CFG_GAIN_P, 0);
        write_reg(CFG_GAIN_D, 0);
        write_reg(CFG_GAIN_I, MAX_GAIN);
        write_reg(CFG_TARGET, 0);
        repeat (INTEG_TICKS) send_tick(HEAD_MAX, DT_MAX);
        repeat (4) send_tick(HALF_TURN + 1, DT_MAX);
    endtask

    // Random turns: new gains and tolerance, usually a new target, then a heading
    // that closes in on the target with some noise and odd intervals mixed in.
    task automatic test_random_moves(input int moves);
        int                ticks;
        int                offset;
        int                h;
        logic [HEAD_W-1:0] meas;
        logic [DT_W-1:0]   dt;
        for (int m = 0; m < moves; m++) begin
            wait_idle();
            write_reg(CFG_GAIN_P, pick_gain());
            write_reg(CFG_GAIN_I, pick_gain());
            write_reg(CFG_GAIN_D, pick_gain());
            write_reg(CFG_TOL, pick_tol());
            if ($urandom_range(0, 4) != 0) begin
                write_reg(CFG_TARGET, pick_target());
            end
            offset = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
            ticks  = $urandom_range(10, 70);
            repeat (ticks) begin
                h    = int'(tgt_heading) - offset;
                h    = ((h % HEADING_MOD) + HEADING_MOD) % HEADING_MOD;
                meas = HEAD_W'(h);
                case ($urandom_range(0, 15))
                    0, 1: meas = HEAD_W'($urandom_range(0, HEAD_MAX));
                    2: begin
                        if (h + HEADING_MOD <= HEAD_MAX) begin
                            meas = HEAD_W'(h + HEADING_MOD);
                        end
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0: dt = '0;
                    1: dt = DT_W'($urandom_range(0, DT_MAX));
                    default: dt = DT_W'($urandom_range(15, 30));
                endcase
                send_tick(meas, dt);
                offset = offset * 3 / 4 + int'($urandom_range(0, 40)) - 20;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        idling = 1'b1;
        test_reset_state();
        test_wrap_and_drive_limits();
        test_derivative_and_rounding();
        test_settling_and_unknown_regs();

        idling = 1'b0;
        test_integral_growth();

        idling = 1'b1;
        test_random_moves(38);

        // Closing stretch runs at full rate on both sides.
        idling = 1'b0;
        test_random_moves(6);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("** heading_pid_turn_top: PASSED **");
        end else begin
            $display("** heading_pid_turn_top: FAILED **");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #TIMEOUT;
        $display("** heading_pid_turn_top: FAILED **");
        $finish;
    end

endmodule
